@@ hw/rtl/lru_order_tracker_top_macros.svh @@
// ----------------------------------------------------------------------------
// lru order tracker assertion macros
// concurrent checks clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef LRU_ORDER_TRACKER_TOP_MACROS_SVH
`define LRU_ORDER_TRACKER_TOP_MACROS_SVH

// property holds at every edge
`define LOT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LOT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define LOT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lot_pkg.sv @@
// ----------------------------------------------------------------------------
// lot_pkg
// shared codes, field widths and parameter defaults of the lru order tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lot_pkg;

  localparam int DepthDefault   = 16;
  localparam int KeyBitsDefault = 16;

  localparam int KindW   = 2;
  localparam int KeyW    = 16;
  localparam int StatusW = 2;

  typedef enum logic [KindW-1:0] {
    KindInsert = 2'd0,
    KindTouch  = 2'd1,
    KindPoll   = 2'd2,
    KindPeek   = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk      = 2'd0,
    StatusFull    = 2'd1,
    StatusEmpty   = 2'd2,
    StatusMissing = 2'd3
  } status_e;

endpackage

@@ hw/rtl/lot_store.sv @@
// ----------------------------------------------------------------------------
// lot_store
// key memory, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lot_store #(
  parameter int DEPTH    = lot_pkg::DepthDefault,
  parameter int KEY_BITS = lot_pkg::KeyBitsDefault,
  localparam int IdxW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  logic [KEY_BITS-1:0] wdata_i,
  input  logic                re_i,
  input  logic [IdxW-1:0]     raddr_i,
  output logic [KEY_BITS-1:0] rdata_o
);
  import lot_pkg::*;

  logic [KEY_BITS-1:0] mem_q [DEPTH];
  logic [KEY_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/lot_ctrl.sv @@
// ----------------------------------------------------------------------------
// lot_ctrl
// request sequencer: ring pointer, count, scan and shift over the key memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_order_tracker_top_macros.svh"

module lot_ctrl #(
  parameter int DEPTH    = lot_pkg::DepthDefault,
  parameter int KEY_BITS = lot_pkg::KeyBitsDefault,
  localparam int IdxW    = $clog2(DEPTH),
  localparam int CntW    = $clog2(DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [lot_pkg::KindW-1:0]  kind_i,
  input  logic [lot_pkg::KeyW-1:0]   key_i,
  output logic                       done_o,
  output logic [lot_pkg::KeyW-1:0]   result_key_o,
  output logic [lot_pkg::StatusW-1:0] status_o,
  output logic [CntW-1:0]            entry_count_o,
  output logic                       is_empty_o,
  output logic                       mem_we_o,
  output logic [IdxW-1:0]            mem_waddr_o,
  output logic [KEY_BITS-1:0]        mem_wdata_o,
  output logic                       mem_re_o,
  output logic [IdxW-1:0]            mem_raddr_o,
  input  logic [KEY_BITS-1:0]        mem_rdata_i
);
  import lot_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StShift = 3'd3;
  localparam logic [2:0] StFinal = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [IdxW-1:0]     head_q, head_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic                poll_q, poll_d;
  logic                done_q, done_d;
  logic [KEY_BITS-1:0] res_key_q, res_key_d;
  status_e             status_q, status_d;

  logic [KEY_BITS-1:0] key_in;
  logic [CntW-1:0]     count_m1;
  logic [IdxW-1:0]     top;
  logic                full;

  // logical slot to physical address, slot 0 at the head pointer
  function automatic logic [IdxW-1:0] phys(input logic [IdxW-1:0] head,
                                           input logic [IdxW-1:0] slot);
    logic [IdxW:0] sum;
    sum = {1'b0, head} + {1'b0, slot};
    if (sum >= (IdxW+1)'(DEPTH)) begin
      sum = sum - (IdxW+1)'(DEPTH);
    end
    return sum[IdxW-1:0];
  endfunction

  assign key_in   = KEY_BITS'(key_i);
  assign count_m1 = count_q - CntW'(1);
  assign top      = count_m1[IdxW-1:0];
  assign full     = (count_q == CntW'(DEPTH));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    head_d      = head_q;
    idx_d       = idx_q;
    key_d       = key_q;
    poll_d      = poll_q;
    done_d      = 1'b0;
    res_key_d   = res_key_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = key_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      StIdle: begin
        if (start_i) begin
          key_d  = key_in;
          poll_d = (kind_i == KindPoll);
          case (kind_i)
            KindInsert: begin
              done_d    = 1'b1;
              res_key_d = key_in;
              if (full) begin
                status_d = StatusFull;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = phys(head_q, count_q[IdxW-1:0]);
                mem_wdata_o = key_in;
                count_d     = count_q + CntW'(1);
                status_d    = StatusOk;
              end
            end
            KindTouch: begin
              res_key_d = key_in;
              if (count_q == '0) begin
                done_d   = 1'b1;
                status_d = StatusMissing;
              end else begin
                // search starts at the most recent slot
                mem_re_o    = 1'b1;
                mem_raddr_o = phys(head_q, top);
                idx_d       = top;
                state_d     = StScan;
              end
            end
            default: begin
              if (count_q == '0) begin
                done_d    = 1'b1;
                status_d  = StatusEmpty;
                res_key_d = '0;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = head_q;
                state_d     = StRead;
              end
            end
          endcase
        end
      end
      StRead: begin
        done_d    = 1'b1;
        status_d  = StatusOk;
        res_key_d = mem_rdata_i;
        if (poll_q) begin
          head_d  = phys(head_q, IdxW'(1));
          count_d = count_m1;
        end
        state_d = StIdle;
      end
      StScan: begin
        if (mem_rdata_i == key_q) begin
          if (idx_q == top) begin
            done_d   = 1'b1;
            status_d = StatusOk;
            state_d  = StIdle;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = phys(head_q, idx_q + IdxW'(1));
            state_d     = StShift;
          end
        end else if (idx_q == '0) begin
          done_d   = 1'b1;
          status_d = StatusMissing;
          state_d  = StIdle;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = phys(head_q, idx_q - IdxW'(1));
          idx_d       = idx_q - IdxW'(1);
        end
      end
      StShift: begin
        // move slot idx+1 down to idx while the next one is read
        mem_we_o    = 1'b1;
        mem_waddr_o = phys(head_q, idx_q);
        mem_wdata_o = mem_rdata_i;
        if (idx_q + IdxW'(1) == top) begin
          state_d = StFinal;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = phys(head_q, idx_q + IdxW'(2));
          idx_d       = idx_q + IdxW'(1);
        end
      end
      StFinal: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = phys(head_q, top);
        mem_wdata_o = key_q;
        done_d      = 1'b1;
        status_d    = StatusOk;
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      head_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    key_q     <= key_d;
    poll_q    <= poll_d;
    res_key_q <= res_key_d;
    status_q  <= status_d;
  end

  assign busy_o        = (state_q != StIdle);
  assign done_o        = done_q;
  assign result_key_o  = KeyW'(res_key_q);
  assign status_o      = status_q;
  assign entry_count_o = count_q;
  assign is_empty_o    = (count_q == '0);

  `LOT_ASSERT_IMPL(a_no_rw_clash, mem_we_o && mem_re_o, mem_waddr_o != mem_raddr_o, "read and write hit one entry")
  `LOT_ASSERT(a_count_range, count_q <= CntW'(DEPTH), "entry count above depth")
  `LOT_ASSERT_NEXT(a_accept_progress, start_i && !busy_o, busy_o || done_o, "accepted request lost")
  `LOT_ASSERT_NEXT(a_count_held, state_q == StScan || state_q == StShift || state_q == StFinal, $stable(count_q), "count moved during touch")
  `LOT_ASSERT_IMPL(a_done_idle, done_o, !busy_o, "result shown while busy")

endmodule

@@ hw/rtl/lru_order_tracker_top.sv @@
// insert, and any refused or empty request: result in the cycle after acceptance
// peek and poll: result after one key memory read, via the StRead state
// touch scans down from the most recent slot, a lower hit shifts newer keys down and
// puts the key on top, a missing key scans all; latency is set by the scan and shift
// busy_o is high until the result strobe; the next request is taken in the strobe cycle
// reset clears count and ring pointer at once; key memory is not cleared, no clearing pass
// ----------------------------------------------------------------------------
// lru_order_tracker_top
// recency stack of keys held in one synchronous memory used as a ring
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_order_tracker_top #(
  parameter int DEPTH    = lot_pkg::DepthDefault,
  parameter int KEY_BITS = lot_pkg::KeyBitsDefault,
  localparam int IdxW    = $clog2(DEPTH),
  localparam int CntW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [lot_pkg::KindW-1:0]   kind_i,
  input  logic [lot_pkg::KeyW-1:0]    key_i,
  output logic                        done_o,
  output logic [lot_pkg::KeyW-1:0]    result_key_o,
  output logic [lot_pkg::StatusW-1:0] status_o,
  output logic [CntW-1:0]             entry_count_o,
  output logic                        is_empty_o
);
  import lot_pkg::*;

  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  logic [KEY_BITS-1:0] mem_wdata;
  logic                mem_re;
  logic [IdxW-1:0]     mem_raddr;
  logic [KEY_BITS-1:0] mem_rdata;

  lot_ctrl #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .key_i         (key_i),
    .done_o        (done_o),
    .result_key_o  (result_key_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  lot_store #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
